@@ rtl/core/spa_pkg.sv @@
// Package for the sparse polynomial adder: sizes, input kind codes and the
// command and status records that join the controller to the datapath.
// No dependencies.
package spa_pkg;

   localparam int TERMS_PER_POLY = 32;
   localparam int COEF_BITS      = 32;
   localparam int POWER_BITS     = 16;
   localparam int SUM_BITS       = COEF_BITS + 1;
   localparam int IDX_BITS       = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
   localparam int CNT_BITS       = $clog2(TERMS_PER_POLY + 1);

   typedef enum logic [1:0] {
      KIND_LOAD_FIRST  = 2'd0,
      KIND_LOAD_SECOND = 2'd1,
      KIND_MERGE       = 2'd2
   } kind_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic step;
      logic clear;
   } spa_cmd_type;

   typedef struct packed {
      logic has_terms;
      logic out_room;
      logic last;
   } spa_stat_type;

endpackage

@@ rtl/core/spa_ctrl.sv @@
// Controller of the sparse polynomial adder: idle/merge state machine.
// Depends on spa_pkg.
module spa_ctrl
   import spa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic [1:0]   req_tuser,
   output logic         req_tready,
   input  spa_stat_type stat,
   output spa_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               unique case (kind_type'(req_tuser))
                  KIND_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  KIND_LOAD_SECOND: cmd.load_second = 1'b1;
                  KIND_MERGE: begin
                     if (stat.has_terms) begin
                        state_in = ST_MERGE;
                        ready_in = 1'b0;
                     end else begin
                        cmd.clear = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (stat.out_room) begin
               cmd.step = 1'b1;
               if (stat.last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
                  ready_in  = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

@@ rtl/core/spa_datapath.sv @@
// Datapath of the sparse polynomial adder: two term stores, fill counts,
// merge pointers, the head compare and add, and the result register.
// Depends on spa_pkg.
module spa_datapath
   import spa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  spa_cmd_type           cmd,
   output spa_stat_type          stat,
   input  logic [31:0]           load_coefficient,
   input  logic [15:0]           load_power,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [SUM_BITS-1:0]   out_coefficient,
   output logic [POWER_BITS-1:0] out_power,
   output logic                  out_last,
   output logic                  out_dropped
);

   logic [COEF_BITS-1:0]  first_coeffs  [TERMS_PER_POLY];
   logic [POWER_BITS-1:0] first_powers  [TERMS_PER_POLY];
   logic [COEF_BITS-1:0]  second_coeffs [TERMS_PER_POLY];
   logic [POWER_BITS-1:0] second_powers [TERMS_PER_POLY];

   logic [CNT_BITS-1:0] first_count_ff, first_count_in;
   logic [CNT_BITS-1:0] second_count_ff, second_count_in;
   logic [CNT_BITS-1:0] a_ff, a_in;
   logic [CNT_BITS-1:0] b_ff, b_in;
   logic                overflow_ff, overflow_in;

   logic                  out_valid_ff, out_valid_in;
   logic [SUM_BITS-1:0]   out_coef_ff, out_coef_in;
   logic [POWER_BITS-1:0] out_power_ff, out_power_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_drop_ff, out_drop_in;

   logic                  first_full, second_full;
   logic                  a_has, b_has, take_a, take_b, take_both;
   logic [COEF_BITS-1:0]  head_ca, head_cb;
   logic [POWER_BITS-1:0] head_pa, head_pb;
   logic [SUM_BITS-1:0]   add_a, add_b;
   logic [CNT_BITS-1:0]   a_next, b_next;

   assign first_full  = (first_count_ff == CNT_BITS'(TERMS_PER_POLY));
   assign second_full = (second_count_ff == CNT_BITS'(TERMS_PER_POLY));

   // store writes at the fill count
   always_ff @(posedge clock) begin
      if (cmd.load_first && !first_full) begin
         first_coeffs[first_count_ff[IDX_BITS-1:0]] <= load_coefficient[COEF_BITS-1:0];
         first_powers[first_count_ff[IDX_BITS-1:0]] <= load_power[POWER_BITS-1:0];
      end
      if (cmd.load_second && !second_full) begin
         second_coeffs[second_count_ff[IDX_BITS-1:0]] <= load_coefficient[COEF_BITS-1:0];
         second_powers[second_count_ff[IDX_BITS-1:0]] <= load_power[POWER_BITS-1:0];
      end
   end

   // merge heads
   assign head_ca = first_coeffs[a_ff[IDX_BITS-1:0]];
   assign head_pa = first_powers[a_ff[IDX_BITS-1:0]];
   assign head_cb = second_coeffs[b_ff[IDX_BITS-1:0]];
   assign head_pb = second_powers[b_ff[IDX_BITS-1:0]];

   assign a_has     = (a_ff < first_count_ff);
   assign b_has     = (b_ff < second_count_ff);
   assign take_both = a_has && b_has && (head_pa == head_pb);
   assign take_a    = a_has && (!b_has || (head_pa > head_pb));
   assign take_b    = b_has && (!a_has || (head_pa < head_pb));

   assign add_a  = (take_a || take_both) ? {head_ca[COEF_BITS-1], head_ca} : '0;
   assign add_b  = (take_b || take_both) ? {head_cb[COEF_BITS-1], head_cb} : '0;
   assign a_next = a_ff + CNT_BITS'(take_a || take_both);
   assign b_next = b_ff + CNT_BITS'(take_b || take_both);

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      overflow_in     = overflow_ff;
      out_valid_in    = out_valid_ff && !out_ready;
      out_coef_in     = out_coef_ff;
      out_power_in    = out_power_ff;
      out_last_in     = out_last_ff;
      out_drop_in     = out_drop_ff;

      if (cmd.load_first) begin
         if (first_full) overflow_in = 1'b1;
         else            first_count_in = first_count_ff + CNT_BITS'(1);
      end
      if (cmd.load_second) begin
         if (second_full) overflow_in = 1'b1;
         else             second_count_in = second_count_ff + CNT_BITS'(1);
      end
      if (cmd.step) begin
         a_in         = a_next;
         b_in         = b_next;
         out_valid_in = 1'b1;
         out_coef_in  = add_a + add_b;
         out_power_in = take_a ? head_pa : head_pb;
         out_last_in  = stat.last;
         out_drop_in  = overflow_ff;
      end
      if (cmd.clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         a_in            = '0;
         b_in            = '0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         a_ff            <= '0;
         b_ff            <= '0;
         overflow_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         a_ff            <= a_in;
         b_ff            <= b_in;
         overflow_ff     <= overflow_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_coef_ff  <= out_coef_in;
      out_power_ff <= out_power_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
   end

   assign stat.has_terms = (first_count_ff != '0) || (second_count_ff != '0);
   assign stat.out_room  = !out_valid_ff || out_ready;
   assign stat.last      = (a_next >= first_count_ff) && (b_next >= second_count_ff);

   assign out_valid       = out_valid_ff;
   assign out_coefficient = out_coef_ff;
   assign out_power       = out_power_ff;
   assign out_last        = out_last_ff;
   assign out_dropped     = out_drop_ff;

endmodule

@@ rtl/core/sparse_polynomial_adder.sv @@
// Top level of the sparse polynomial adder: controller plus datapath.
// Depends on spa_pkg, spa_ctrl and spa_datapath.
//
//   channel | dir | tdata                                   | tuser        | tlast
//   req_    | in  | coefficient[31:0], power[47:32]         | kind[1:0]    | -
//   rsp_    | out | sum_coefficient[32:0], sum_power[48:33] | terms_dropped| last_term
//
// A load word yields no result. A merge word emits one sum term per cycle
// while rsp_ has room, up to twice the store depth, each term formed by
// the single compare-and-add over the two store heads.
// reset (synchronous, active high) empties both stores and the result register.
// A stall on rsp_ holds the current term; the next one is formed when it is taken.
// req_tready drops after a merge word on non-empty stores and rises once its last term is formed.
module sparse_polynomial_adder
   import spa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coefficient[31:0], power[47:32]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // sum_coefficient[32:0], sum_power[48:33], zero
   output logic        rsp_tuser,   // terms_dropped
   output logic        rsp_tlast    // last_term
);

   spa_cmd_type           cmd;
   spa_stat_type          stat;
   logic [SUM_BITS-1:0]   sum_coefficient;
   logic [POWER_BITS-1:0] sum_power;

   spa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .load_coefficient (req_tdata[31:0]),
      .load_power       (req_tdata[47:32]),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_coefficient  (sum_coefficient),
      .out_power        (sum_power),
      .out_last         (rsp_tlast),
      .out_dropped      (rsp_tuser)
   );

   // pack the result word, zero fill to whole bytes
   assign rsp_tdata = {7'd0, sum_power, sum_coefficient};

endmodule

@@ rtl/core/spa_checker.sv @@
// Port-level checks for the sparse polynomial adder, bound to the top level.
// Depends on sparse_polynomial_adder's ports only.
module spa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // reset drops any pending result
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // no new word accepted while a merge is still emitting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready in the middle of a merge");

   // terms of one merge follow without gaps and share the dropped flag
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && (rsp_tuser == $past(rsp_tuser)))
      else $error("merge burst broken or dropped flag changed");

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (.*);

@@ sim/tb.sv @@
// Self-checking bench for sparse_polynomial_adder: a directed script, then random load/merge runs.
// Expected terms come from a behavioral model or the script rows; depends on spa_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import spa_pkg::*;

   // Unused kind code: the block accepts such a word and ignores it.
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   typedef struct {
      logic [SUM_BITS-1:0]   coef;
      logic [POWER_BITS-1:0] pow;
      logic                  last;
      logic                  dropped;
   } term_word_type;

   // One scripted word. fixed_terms: -1 take the model's terms, 0 expect none,
   // 1 expect the single term typed into want_coef / want_pow.
   typedef struct {
      logic [1:0]            kind;
      logic [COEF_BITS-1:0]  coef;
      logic [POWER_BITS-1:0] pow;
      int                    fixed_terms;
      logic [SUM_BITS-1:0]   want_coef;
      logic [POWER_BITS-1:0] want_pow;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;   // coefficient[31:0], power[47:32]
   logic [1:0]          req_tuser = '0;   // kind[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [55:0]         rsp_tdata;        // sum_coefficient[32:0], sum_power[48:33], zero
   logic                rsp_tuser;        // terms_dropped
   logic                rsp_tlast;        // last_term

   // Model state: two term stores, their fill counts and the overflow flag.
   logic signed [COEF_BITS-1:0] coef_store [2][TERMS_PER_POLY];
   logic [POWER_BITS-1:0]       pow_store  [2][TERMS_PER_POLY];
   int                          store_count [2] = '{0, 0};
   logic                        overflow_seen = 1'b0;

   term_word_type  merged_terms[$];   // terms produced by the word just modeled
   term_word_type  pending_terms[$];  // terms still owed by the block, oldest first
   script_row_type script[$];
   int             fail_count = 0;
   int             loaded_words = 0;
   bit             steady_flow = 1'b0; // when set, both sides run without gaps

   sparse_polynomial_adder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a term.
   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

   // Advance the model by one accepted word. Loads fill a store (or flag an
   // overflow when it is full); a merge walks both store heads like a merge
   // sort, then empties both stores and clears the flag.
   task automatic predict_word(input logic [1:0] kind, input logic [COEF_BITS-1:0] coef,
                               input logic [POWER_BITS-1:0] pow);
      int a;
      int b;
      int s;
      term_word_type t;
      merged_terms.delete();
      if (kind == KIND_LOAD_FIRST || kind == KIND_LOAD_SECOND) begin
         s = (kind == KIND_LOAD_FIRST) ? 0 : 1;
         if (store_count[s] >= TERMS_PER_POLY) begin
            overflow_seen = 1'b1;
         end else begin
            coef_store[s][store_count[s]] = coef;
            pow_store[s][store_count[s]]  = pow;
            store_count[s]++;
         end
      end else if (kind == KIND_MERGE) begin
         a = 0;
         b = 0;
         while (a < store_count[0] || b < store_count[1]) begin
            if (b >= store_count[1] ||
                (a < store_count[0] && pow_store[0][a] > pow_store[1][b])) begin
               t.coef = coef_store[0][a];   // sign-extends to the sum width
               t.pow  = pow_store[0][a];
               a++;
            end else if (a >= store_count[0] || pow_store[0][a] < pow_store[1][b]) begin
               t.coef = coef_store[1][b];
               t.pow  = pow_store[1][b];
               b++;
            end else begin
               // equal powers: add, and keep the term even when the sum is zero
               t.coef = coef_store[0][a] + coef_store[1][b];
               t.pow  = pow_store[1][b];
               a++;
               b++;
            end
            t.last    = (a >= store_count[0] && b >= store_count[1]);
            t.dropped = overflow_seen;
            merged_terms.push_back(t);
         end
         store_count[0] = 0;
         store_count[1] = 0;
         overflow_seen  = 1'b0;
      end
   endtask

   // Offer one word after a random gap, hold it until taken, then update the
   // model. Keep tvalid high across back-to-back words.
   task automatic send_word(input logic [1:0] kind, input logic [COEF_BITS-1:0] coef,
                            input logic [POWER_BITS-1:0] pow, input bit use_model);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pow, coef};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_word(kind, coef, pow);
      if (use_model) begin
         foreach (merged_terms[i]) pending_terms.push_back(merged_terms[i]);
      end
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [COEF_BITS-1:0] coef,
                          input logic [POWER_BITS-1:0] pow, input int fixed_terms,
                          input logic [SUM_BITS-1:0] want_coef,
                          input logic [POWER_BITS-1:0] want_pow);
      script_row_type r;
      r.kind        = kind;
      r.coef        = coef;
      r.pow         = pow;
      r.fixed_terms = fixed_terms;
      r.want_coef   = want_coef;
      r.want_pow    = want_pow;
      script.push_back(r);
   endtask

   // One random pair of polynomials followed by a merge. Most runs are short
   // and in descending power order with nearby powers, so equal powers meet
   // often; some overrun the store depth, some come unordered, and a few
   // ignored words are mixed in as noise.
   task automatic random_pair();
      int want [2];
      int sent [2];
      logic [POWER_BITS-1:0] next_pow [2];
      logic [COEF_BITS-1:0]  coef;
      int side;
      int style;
      style = $urandom_range(0, 9);
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 2; s++) begin
         want[s] = (style == 0) ? $urandom_range(26, 36) : $urandom_range(0, 6);
         sent[s] = 0;
         next_pow[s] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      end
      if ($urandom_range(0, 1) == 1) next_pow[1] = next_pow[0];
      while (sent[0] < want[0] || sent[1] < want[1]) begin
         if ($urandom_range(0, 24) == 0) send_word(KIND_IGNORED, $urandom, 16'($urandom), 1'b1);
         side = (sent[0] >= want[0]) ? 1 : (sent[1] >= want[1]) ? 0 : $urandom_range(0, 1);
         case ($urandom_range(0, 7))
            0: coef = 32'h7fff_ffff;
            1: coef = 32'h8000_0000;
            2: coef = 32'($urandom_range(0, 20)) - 32'd10;
            default: coef = $urandom;
         endcase
         send_word((side == 0) ? KIND_LOAD_FIRST : KIND_LOAD_SECOND, coef, next_pow[side], 1'b1);
         sent[side]++;
         if (style == 1) begin
            next_pow[side] = 16'($urandom_range(0, 40));
         end else begin
            next_pow[side] = (next_pow[side] > 16'd3) ?
                             next_pow[side] - 16'($urandom_range(1, 3)) : 16'd0;
         end
      end
      send_word(KIND_MERGE, $urandom, 16'($urandom), 1'b1);
      loaded_words += want[0] + want[1] + 1;
   endtask

   // Result side: stall for a random gap before each word.
   initial begin : result_sink
      int stall;
      @(negedge reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check every taken sum term against the oldest expected one.
   always @(posedge clock) begin : check_terms
      term_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_terms.size() == 0) begin
            $error("unexpected sum term: coef %h power %0d",
                   rsp_tdata[SUM_BITS-1:0], rsp_tdata[SUM_BITS+POWER_BITS-1:SUM_BITS]);
            fail_count++;
         end else begin
            want = pending_terms.pop_front();
            if (rsp_tdata[SUM_BITS-1:0] !== want.coef) begin
               $error("sum_coefficient: expected %h, got %h", want.coef,
                      rsp_tdata[SUM_BITS-1:0]);
               fail_count++;
            end
            if (rsp_tdata[SUM_BITS+POWER_BITS-1:SUM_BITS] !== want.pow) begin
               $error("sum_power: expected %0d, got %0d", want.pow,
                      rsp_tdata[SUM_BITS+POWER_BITS-1:SUM_BITS]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_term: expected %b, got %b", want.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== want.dropped) begin
               $error("terms_dropped: expected %b, got %b", want.dropped, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      term_word_type t;

      // Empty merge, single-term extremes, overflowing sums, a zero sum,
      // an ignored kind, unordered loads and an interleaved pair.
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     0, '0, '0);
      add_row(KIND_LOAD_FIRST,  32'h7fff_ffff, 16'hffff, -1, '0, '0);
      add_row(KIND_MERGE,       32'hffff_ffff, 16'hffff,  1, 33'h0_7fff_ffff, 16'hffff);
      add_row(KIND_LOAD_SECOND, 32'h8000_0000, 16'd0,    -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     1, 33'h1_8000_0000, 16'd0);
      add_row(KIND_LOAD_FIRST,  32'h8000_0000, 16'd100,  -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'h8000_0000, 16'd100,  -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     1, 33'h1_0000_0000, 16'd100);
      add_row(KIND_LOAD_FIRST,  32'h7fff_ffff, 16'd7,    -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'h7fff_ffff, 16'd7,    -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     1, 33'h0_ffff_fffe, 16'd7);
      add_row(KIND_LOAD_FIRST,  32'd5,         16'd3,    -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'hffff_fffb, 16'd3,    -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     1, 33'h0_0000_0000, 16'd3);
      add_row(KIND_IGNORED,     32'hffff_ffff, 16'hffff, -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,     0, '0, '0);
      add_row(KIND_LOAD_FIRST,  32'd1,         16'd2,    -1, '0, '0);
      add_row(KIND_LOAD_FIRST,  32'd1,         16'd9,    -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'd1,         16'd5,    -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,    -1, '0, '0);
      add_row(KIND_LOAD_FIRST,  32'd10,        16'd50,   -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'd1,         16'd40,   -1, '0, '0);
      add_row(KIND_LOAD_FIRST,  32'd20,        16'd30,   -1, '0, '0);
      add_row(KIND_LOAD_SECOND, 32'd2,         16'd30,   -1, '0, '0);
      add_row(KIND_MERGE,       32'h0000_0000, 16'd0,    -1, '0, '0);

      // Hold reset from the start, then release it once.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_word(script[i].kind, script[i].coef, script[i].pow, script[i].fixed_terms < 0);
         if (script[i].fixed_terms > 0) begin
            t.coef    = script[i].want_coef;
            t.pow     = script[i].want_pow;
            t.last    = 1'b1;
            t.dropped = 1'b0;
            pending_terms.push_back(t);
         end
      end

      while (loaded_words < 300) random_pair();
      req_tvalid <= 1'b0;

      // Drain: wait for every owed term, then watch a while for strays.
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
